>>> design/cbez_pkg.sv
// Shared constants, register index codes and status types for the cubic Bezier evaluator.
package cbez_pkg;

   localparam int COORD_BITS_DEFAULT = 32;
   localparam int FRAC_BITS_DEFAULT  = 16;
   localparam int NUM_CTRL_REGS      = 8;
   localparam int CSR_INDEX_BITS     = 4;
   localparam int QUEUE_DEPTH        = 2;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_CTRL0_X = 4'd0,
      CSR_CTRL0_Y = 4'd1,
      CSR_CTRL1_X = 4'd2,
      CSR_CTRL1_Y = 4'd3,
      CSR_CTRL2_X = 4'd4,
      CSR_CTRL2_Y = 4'd5,
      CSR_CTRL3_X = 4'd6,
      CSR_CTRL3_Y = 4'd7
   } csr_index_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

endpackage

>>> design/cbez_front.sv
// Front end: accept a parameter, clamp it to one and hand it to the queue.
module cbez_front #(
   parameter int FRAC_BITS = cbez_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [FRAC_BITS:0]         param_t,
   input  cbez_pkg::queue_stat_type   q_stat,
   output logic                       busy,
   output logic                       push,
   output logic [FRAC_BITS:0]         push_t
);

   localparam logic [FRAC_BITS:0] T_ONE = {1'b1, {FRAC_BITS{1'b0}}};

   logic               front_valid_ff;
   logic               front_valid_in;
   logic [FRAC_BITS:0] front_t_ff;
   logic [FRAC_BITS:0] clamp_t;
   logic               accept;

   // anything above one is taken as one
   assign clamp_t = (param_t[FRAC_BITS] && (|param_t[FRAC_BITS-1:0])) ? T_ONE : param_t;

   assign push           = front_valid_ff && !q_stat.full;
   assign busy           = front_valid_ff && q_stat.full;
   assign accept         = start && !busy;
   assign front_valid_in = accept || (front_valid_ff && !push);
   assign push_t         = front_t_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         front_t_ff <= clamp_t;
      end
   end

endmodule

>>> design/cbez_queue.sv
// Short queue between the front end and the evaluation pipeline.
module cbez_queue #(
   parameter int WIDTH = cbez_pkg::FRAC_BITS_DEFAULT + 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  logic [WIDTH-1:0]          push_data,
   input  logic                      pop,
   output logic [WIDTH-1:0]          pop_data,
   output cbez_pkg::queue_stat_type  q_stat
);

   localparam int DEPTH = cbez_pkg::QUEUE_DEPTH;
   localparam int PTRW  = $clog2(DEPTH);
   localparam int CNTW  = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTRW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTRW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]  count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign q_stat.full  = (count_ff == CNTW'(DEPTH));
   assign q_stat.empty = (count_ff == '0);

   assign do_push = push && !q_stat.full;
   assign do_pop  = pop && !q_stat.empty;

   assign wr_ptr_in = !do_push ? wr_ptr_ff :
                      (wr_ptr_ff == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_ptr_in = !do_pop ? rd_ptr_ff :
                      (rd_ptr_ff == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   assign pop_data = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   // the front end never offers a transaction into a full queue
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_stat.full)
      else $error("push into full queue");

   a_push_fills: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> !q_stat.empty)
      else $error("queue empty after push");

endmodule

>>> design/cbez_back.sv
// Evaluation pipeline: de Casteljau point and derivative for both axes.
module cbez_back #(
   parameter int COORD_BITS = cbez_pkg::COORD_BITS_DEFAULT,
   parameter int FRAC_BITS  = cbez_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                               clock,
   input  logic                                               reset,
   input  logic                                               pop,
   input  logic [FRAC_BITS:0]                                 pop_t,
   input  logic [cbez_pkg::NUM_CTRL_REGS-1:0][COORD_BITS-1:0] ctrl,
   output logic                                               rsp_strobe,
   output logic [COORD_BITS-1:0]                              curve_x,
   output logic [COORD_BITS-1:0]                              curve_y,
   output logic [COORD_BITS-1:0]                              slope_x,
   output logic [COORD_BITS-1:0]                              slope_y
);

   localparam int CW = COORD_BITS;
   localparam int DW = CW + 1;
   localparam int EW = CW + 2;
   localparam int TW = FRAC_BITS + 1;
   localparam int PW = EW + TW + 1;
   localparam int SW = CW + 3;
   localparam int NSTAGE = 9;

   localparam logic signed [PW-1:0] HALF =
      {{(PW-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
   localparam logic signed [SW-1:0] SMAX = {4'b0000, {(CW-1){1'b1}}};
   localparam logic signed [SW-1:0] SMIN = {4'b1111, {(CW-1){1'b0}}};

   // round a scaled product to nearest, ties toward plus infinity
   function automatic logic signed [EW-1:0] rnd(input logic signed [PW-1:0] m);
      logic signed [PW-1:0] sum;
      sum = m + HALF;
      return $signed(sum[FRAC_BITS +: EW]);
   endfunction

   logic [NSTAGE:1] valid_ff;
   logic [TW-1:0]   t1_ff, t2_ff, t3_ff, t4_ff, t5_ff, t6_ff, t7_ff;

   logic [CW-1:0] curve_w [2];
   logic [CW-1:0] slope_w [2];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[NSTAGE-1:1], pop};
      end
   end

   always_ff @(posedge clock) begin
      t1_ff <= pop_t;
      t2_ff <= t1_ff;
      t3_ff <= t2_ff;
      t4_ff <= t3_ff;
      t5_ff <= t4_ff;
      t6_ff <= t5_ff;
      t7_ff <= t6_ff;
   end

   for (genvar ax = 0; ax < 2; ax++) begin : g_axis
      logic signed [CW-1:0] p0, p1, p2, p3;
      logic signed [DW-1:0] s0_d0, s0_d1, s0_d2;
      logic signed [EW-1:0] s0_g0, s0_g1;
      // stage 1: control points and differences
      logic signed [CW-1:0] s1_p0_ff, s1_p1_ff, s1_p2_ff;
      logic signed [DW-1:0] s1_d0_ff, s1_d1_ff, s1_d2_ff;
      logic signed [EW-1:0] s1_g0_ff, s1_g1_ff;
      // stage 2: first-level products
      logic signed [CW-1:0] s2_p0_ff, s2_p1_ff, s2_p2_ff;
      logic signed [DW-1:0] s2_d0_ff, s2_d1_ff;
      logic signed [PW-1:0] s2_ma_ff, s2_mb_ff, s2_mc_ff, s2_me0_ff, s2_me1_ff;
      // stage 3: first-level interpolants
      logic signed [EW-1:0] s3_a_sum, s3_b_sum, s3_c_sum, s3_e0_sum, s3_e1_sum;
      logic signed [CW-1:0] s3_a_ff, s3_b_ff, s3_c_ff;
      logic signed [DW-1:0] s3_e0_ff, s3_e1_ff;
      // stage 4: second-level differences
      logic signed [CW-1:0] s4_a_ff, s4_b_ff;
      logic signed [DW-1:0] s4_e0_ff, s4_hab_ff, s4_hbc_ff;
      logic signed [EW-1:0] s4_he_ff;
      // stage 5: second-level products
      logic signed [CW-1:0] s5_a_ff, s5_b_ff;
      logic signed [DW-1:0] s5_e0_ff;
      logic signed [PW-1:0] s5_mab_ff, s5_mbc_ff, s5_me_ff;
      // stage 6: second-level interpolants
      logic signed [EW-1:0] s6_ab_sum, s6_bc_sum, s6_e_sum;
      logic signed [CW-1:0] s6_ab_ff, s6_bc_ff;
      logic signed [DW-1:0] s6_e_ff;
      // stage 7: last difference and saturated derivative
      logic signed [SW-1:0] s7_tri;
      logic signed [CW-1:0] s7_slope;
      logic signed [CW-1:0] s7_ab_ff, s7_slope_ff;
      logic signed [DW-1:0] s7_q_ff;
      // stage 8: last product
      logic signed [CW-1:0] s8_ab_ff, s8_slope_ff;
      logic signed [PW-1:0] s8_mq_ff;
      // stage 9: result
      logic signed [EW-1:0] s9_sum;
      logic [CW-1:0]        curve_ff, slope_ff;

      assign p0 = $signed(ctrl[ax]);
      assign p1 = $signed(ctrl[2 + ax]);
      assign p2 = $signed(ctrl[4 + ax]);
      assign p3 = $signed(ctrl[6 + ax]);

      assign s0_d0 = DW'(p1) - DW'(p0);
      assign s0_d1 = DW'(p2) - DW'(p1);
      assign s0_d2 = DW'(p3) - DW'(p2);
      assign s0_g0 = EW'(s0_d1) - EW'(s0_d0);
      assign s0_g1 = EW'(s0_d2) - EW'(s0_d1);

      assign s3_a_sum  = EW'(s2_p0_ff) + rnd(s2_ma_ff);
      assign s3_b_sum  = EW'(s2_p1_ff) + rnd(s2_mb_ff);
      assign s3_c_sum  = EW'(s2_p2_ff) + rnd(s2_mc_ff);
      assign s3_e0_sum = EW'(s2_d0_ff) + rnd(s2_me0_ff);
      assign s3_e1_sum = EW'(s2_d1_ff) + rnd(s2_me1_ff);

      assign s6_ab_sum = EW'(s5_a_ff) + rnd(s5_mab_ff);
      assign s6_bc_sum = EW'(s5_b_ff) + rnd(s5_mbc_ff);
      assign s6_e_sum  = EW'(s5_e0_ff) + rnd(s5_me_ff);

      // three times the derivative interpolant, clipped to the coordinate range
      assign s7_tri   = SW'(s6_e_ff) + (SW'(s6_e_ff) <<< 1);
      assign s7_slope = (s7_tri > SMAX) ? SMAX[CW-1:0] :
                        (s7_tri < SMIN) ? SMIN[CW-1:0] : s7_tri[CW-1:0];

      assign s9_sum = EW'(s8_ab_ff) + rnd(s8_mq_ff);

      always_ff @(posedge clock) begin
         s1_p0_ff <= p0;
         s1_p1_ff <= p1;
         s1_p2_ff <= p2;
         s1_d0_ff <= s0_d0;
         s1_d1_ff <= s0_d1;
         s1_d2_ff <= s0_d2;
         s1_g0_ff <= s0_g0;
         s1_g1_ff <= s0_g1;

         s2_p0_ff  <= s1_p0_ff;
         s2_p1_ff  <= s1_p1_ff;
         s2_p2_ff  <= s1_p2_ff;
         s2_d0_ff  <= s1_d0_ff;
         s2_d1_ff  <= s1_d1_ff;
         s2_ma_ff  <= PW'(s1_d0_ff) * PW'($signed({1'b0, t1_ff}));
         s2_mb_ff  <= PW'(s1_d1_ff) * PW'($signed({1'b0, t1_ff}));
         s2_mc_ff  <= PW'(s1_d2_ff) * PW'($signed({1'b0, t1_ff}));
         s2_me0_ff <= PW'(s1_g0_ff) * PW'($signed({1'b0, t1_ff}));
         s2_me1_ff <= PW'(s1_g1_ff) * PW'($signed({1'b0, t1_ff}));

         s3_a_ff  <= s3_a_sum[CW-1:0];
         s3_b_ff  <= s3_b_sum[CW-1:0];
         s3_c_ff  <= s3_c_sum[CW-1:0];
         s3_e0_ff <= s3_e0_sum[DW-1:0];
         s3_e1_ff <= s3_e1_sum[DW-1:0];

         s4_a_ff   <= s3_a_ff;
         s4_b_ff   <= s3_b_ff;
         s4_e0_ff  <= s3_e0_ff;
         s4_hab_ff <= DW'(s3_b_ff) - DW'(s3_a_ff);
         s4_hbc_ff <= DW'(s3_c_ff) - DW'(s3_b_ff);
         s4_he_ff  <= EW'(s3_e1_ff) - EW'(s3_e0_ff);

         s5_a_ff   <= s4_a_ff;
         s5_b_ff   <= s4_b_ff;
         s5_e0_ff  <= s4_e0_ff;
         s5_mab_ff <= PW'(s4_hab_ff) * PW'($signed({1'b0, t4_ff}));
         s5_mbc_ff <= PW'(s4_hbc_ff) * PW'($signed({1'b0, t4_ff}));
         s5_me_ff  <= PW'(s4_he_ff) * PW'($signed({1'b0, t4_ff}));

         s6_ab_ff <= s6_ab_sum[CW-1:0];
         s6_bc_ff <= s6_bc_sum[CW-1:0];
         s6_e_ff  <= s6_e_sum[DW-1:0];

         s7_ab_ff    <= s6_ab_ff;
         s7_q_ff     <= DW'(s6_bc_ff) - DW'(s6_ab_ff);
         s7_slope_ff <= s7_slope;

         s8_ab_ff    <= s7_ab_ff;
         s8_slope_ff <= s7_slope_ff;
         s8_mq_ff    <= PW'(s7_q_ff) * PW'($signed({1'b0, t7_ff}));

         curve_ff <= s9_sum[CW-1:0];
         slope_ff <= s8_slope_ff;
      end

      assign curve_w[ax] = curve_ff;
      assign slope_w[ax] = slope_ff;
   end

   assign rsp_strobe = valid_ff[NSTAGE];
   assign curve_x    = curve_w[0];
   assign curve_y    = curve_w[1];
   assign slope_x    = slope_w[0];
   assign slope_y    = slope_w[1];

   // every transaction taken from the queue leaves the pipeline with a result strobe
   a_pipe_latency: assert property (@(posedge clock) disable iff (reset)
      pop |-> ##9 rsp_strobe)
      else $error("result strobe missing after pop");

endmodule

>>> design/cubic_bezier_point_and_tangent.sv
// Top level of the cubic Bezier point and tangent evaluator.
//
// Usage:
//  - Control points: write the eight coordinates (signed Q16.16) through the csr_
//    channel; csr_ready is always high, so a transaction completes whenever
//    csr_valid is high. Indexes beyond the eighth register are dropped. Write only
//    while no parameter is in flight.
//  - Parameters: drive req_param_t (unsigned Q1.16, values above one act as one)
//    and raise start; the transaction is taken at an edge where busy is low.
//  - Results: rsp_strobe marks one cycle carrying the point and the derivative;
//    the receiver takes it at the end of that cycle and cannot hold it off.
//  - From the accepting edge to the strobe cycle a parameter passes the front
//    register, then the queue, then the evaluation pipeline.
//  - Throughput is one parameter per cycle, set by the single-issue front register
//    feeding a fully pipelined back end that never stalls; busy stays low.
//  - Reset (synchronous, active high) empties the front, queue and pipeline and
//    clears all control points to zero.
module cubic_bezier_point_and_tangent #(
   parameter int COORD_BITS = cbez_pkg::COORD_BITS_DEFAULT,
   parameter int FRAC_BITS  = cbez_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [FRAC_BITS:0]                  req_param_t,
   output logic                                rsp_strobe,
   output logic signed [COORD_BITS-1:0]        rsp_curve_x,
   output logic signed [COORD_BITS-1:0]        rsp_curve_y,
   output logic signed [COORD_BITS-1:0]        rsp_slope_x,
   output logic signed [COORD_BITS-1:0]        rsp_slope_y,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [cbez_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [COORD_BITS-1:0]               csr_data
);

   localparam int NREG = cbez_pkg::NUM_CTRL_REGS;

   logic [NREG-1:0][COORD_BITS-1:0] ctrl_ff, ctrl_in;
   cbez_pkg::queue_stat_type        q_stat;
   logic                            push;
   logic [FRAC_BITS:0]              push_t;
   logic                            pop;
   logic [FRAC_BITS:0]              pop_t;

   // the register file takes every write at once
   assign csr_ready = 1'b1;

   // decode the register index; unknown indexes leave the control points as they are
   always_comb begin
      ctrl_in = ctrl_ff;
      if (csr_valid) begin
         case (csr_index)
            cbez_pkg::CSR_CTRL0_X: ctrl_in[0] = csr_data;
            cbez_pkg::CSR_CTRL0_Y: ctrl_in[1] = csr_data;
            cbez_pkg::CSR_CTRL1_X: ctrl_in[2] = csr_data;
            cbez_pkg::CSR_CTRL1_Y: ctrl_in[3] = csr_data;
            cbez_pkg::CSR_CTRL2_X: ctrl_in[4] = csr_data;
            cbez_pkg::CSR_CTRL2_Y: ctrl_in[5] = csr_data;
            cbez_pkg::CSR_CTRL3_X: ctrl_in[6] = csr_data;
            cbez_pkg::CSR_CTRL3_Y: ctrl_in[7] = csr_data;
            default: ctrl_in = ctrl_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else begin
         ctrl_ff <= ctrl_in;
      end
   end

   // front end: accept and clamp the parameter
   cbez_front #(
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .param_t (req_param_t),
      .q_stat  (q_stat),
      .busy    (busy),
      .push    (push),
      .push_t  (push_t)
   );

   // queue decouples the front end from the pipeline
   cbez_queue #(
      .WIDTH (FRAC_BITS + 1)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_t),
      .pop       (pop),
      .pop_data  (pop_t),
      .q_stat    (q_stat)
   );

   // the pipeline never stalls: drain the queue whenever it holds a parameter
   assign pop = !q_stat.empty;

   cbez_back #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop        (pop),
      .pop_t      (pop_t),
      .ctrl       (ctrl_ff),
      .rsp_strobe (rsp_strobe),
      .curve_x    (rsp_curve_x),
      .curve_y    (rsp_curve_y),
      .slope_x    (rsp_slope_x),
      .slope_y    (rsp_slope_y)
   );

endmodule
